[sv/phbm_pkg.sv]
// Shared types and constants of the peak-hold bar meter.
// Used by phbm_band_update and peak_hold_bar_meter_unit; depends on nothing.
package phbm_pkg;

  // Field widths.
  localparam int unsigned BAND_W   = 5;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned LEVEL_W  = 11;
  localparam int unsigned SPEED_W  = 8;
  localparam int unsigned HOLD_W   = 6;
  localparam int unsigned PROD_W   = SAMPLE_W + LEVEL_W;
  localparam int unsigned SUM_W    = PROD_W + 1;
  localparam int unsigned FRAC_W   = 15;
  localparam int unsigned SCALED_W = SUM_W - FRAC_W;
  localparam int unsigned OUT_MAX  = 32;

  // Saturation limits.
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 11'd2047;
  localparam logic [SPEED_W-1:0] SPEED_MAX = 8'd255;
  localparam logic [HOLD_W-1:0]  HOLD_MAX  = 6'd63;

  // Rounding constant for the ceiling of a Q1.15 product.
  localparam logic [SUM_W-1:0] ROUND_UP = 28'd32767;

  // Command codes.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Configuration register indexes.
  localparam logic REG_DISPLAY_HEIGHT = 1'b0;
  localparam logic REG_HOLD_TICKS     = 1'b1;

  // Configuration reset values.
  localparam logic [LEVEL_W-1:0] HEIGHT_RESET = 11'd256;
  localparam logic [HOLD_W-1:0]  HOLD_RESET   = 6'd12;

  // State of one band.
  typedef struct packed {
    logic [LEVEL_W-1:0] bar;
    logic [LEVEL_W-1:0] peak;
    logic [SPEED_W-1:0] bar_speed;
    logic [SPEED_W-1:0] peak_speed;
    logic [HOLD_W-1:0]  hold;
  } band_rec_t;

  localparam band_rec_t RESET_REC = '{
    bar:        11'd1,
    peak:       11'd0,
    bar_speed:  8'd1,
    peak_speed: 8'd1,
    hold:       6'd0
  };

  // Control of the shared band update unit.
  typedef struct packed {
    logic               is_tick;
    logic [LEVEL_W-1:0] value;
    logic [HOLD_W-1:0]  hold_ticks;
  } upd_ctrl_t;

endpackage

[sv/phbm_band_update.sv]
// Shared update unit: computes the next state of one band for a load or a tick.
// Depends on phbm_pkg for the band record, control struct and limits.
module phbm_band_update (
  input  phbm_pkg::upd_ctrl_t ctrl_i,
  input  phbm_pkg::band_rec_t cur_i,
  output phbm_pkg::band_rec_t nxt_o
);

  logic                         bar_above;
  logic                         peak_above;
  logic                         hold_done;
  logic [phbm_pkg::LEVEL_W-1:0] bar_drop;
  logic [phbm_pkg::LEVEL_W-1:0] peak_drop;

  // Fall amounts widened to the level width.
  assign bar_drop  = phbm_pkg::LEVEL_W'(cur_i.bar_speed);
  assign peak_drop = phbm_pkg::LEVEL_W'(cur_i.peak_speed);

  assign bar_above  = ctrl_i.value > cur_i.bar;
  assign peak_above = ctrl_i.value > cur_i.peak;
  assign hold_done  = cur_i.hold >= ctrl_i.hold_ticks;

  // A load only raises levels; a tick lets the bar fall, and the peak once its hold is over, with growing speed.
  always_comb begin
    nxt_o = cur_i;
    if (ctrl_i.is_tick) begin
      nxt_o.bar = (cur_i.bar > bar_drop) ? cur_i.bar - bar_drop : '0;
      if (cur_i.bar_speed != phbm_pkg::SPEED_MAX) begin
        nxt_o.bar_speed = cur_i.bar_speed + 1'b1;
      end
      if (hold_done) begin
        nxt_o.peak = (cur_i.peak > peak_drop) ? cur_i.peak - peak_drop : '0;
        if (cur_i.peak_speed != phbm_pkg::SPEED_MAX) begin
          nxt_o.peak_speed = cur_i.peak_speed + 1'b1;
        end
      end
      if (cur_i.hold != phbm_pkg::HOLD_MAX) begin
        nxt_o.hold = cur_i.hold + 1'b1;
      end
    end else begin
      if (bar_above) begin
        nxt_o.bar        = ctrl_i.value;
        nxt_o.bar_speed  = '0;
        nxt_o.peak_speed = '0;
      end
      if (peak_above) begin
        nxt_o.peak       = ctrl_i.value;
        nxt_o.peak_speed = '0;
        nxt_o.hold       = '0;
      end
    end
  end

endmodule

[sv/peak_hold_bar_meter_unit.sv]
// Top level of the peak-hold bar meter: sequencer, band state memory and output register.
// Depends on phbm_pkg and instantiates phbm_band_update.
//
//  Channel  | Direction | Handshake              | Payload
//  ---------+-----------+------------------------+------------------------------------------
//  in       | in        | in_valid_i / in_stall_o | in_command_i, in_band_i, in_sample_value_i
//  out      | out       | out_valid_o / out_stall_i | out_band_index_o, out_bar_level_o,
//           |           |                        | out_peak_level_o, out_last_o
//  cfg      | in        | cfg_we_i               | cfg_idx_i, cfg_wdata_i
//
// A load passes three steps: transfer and memory read, multiply, update and write-back.
// A tick walks all bands: one band per cycle, unless a stalled output holds the walk, passes
// the shared update unit while the next band is read from the single-port-read memory.
// After reset every band reads as its reset state through per-band valid bits; no
// clearing pass is needed. A stalled output holds the sequencer until the result moves on.
module peak_hold_bar_meter_unit #(
  parameter int unsigned BANDS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          in_command_i,
  input  logic [phbm_pkg::BAND_W-1:0]   in_band_i,
  input  logic [phbm_pkg::SAMPLE_W-1:0] in_sample_value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [phbm_pkg::BAND_W-1:0]   out_band_index_o,
  output logic [phbm_pkg::LEVEL_W-1:0]  out_bar_level_o,
  output logic [phbm_pkg::LEVEL_W-1:0]  out_peak_level_o,
  output logic                          out_last_o,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [phbm_pkg::LEVEL_W-1:0]  cfg_wdata_i
);

  localparam int unsigned IW   = (BANDS > 1) ? $clog2(BANDS) : 1;
  localparam int unsigned NOUT = (BANDS < phbm_pkg::OUT_MAX) ? BANDS : phbm_pkg::OUT_MAX;
  localparam logic [IW-1:0] LAST_BAND = IW'(BANDS - 1);
  localparam logic [IW-1:0] LAST_OUT  = IW'(NOUT - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LD_MUL,
    ST_LD_UPD,
    ST_TICK
  } state_e;

  state_e                         state_q;
  logic [IW-1:0]                  band_q;
  logic [phbm_pkg::SAMPLE_W-1:0]  sample_q;
  logic [phbm_pkg::PROD_W-1:0]    product_q;
  logic [phbm_pkg::LEVEL_W-1:0]   height_q;
  logic [phbm_pkg::HOLD_W-1:0]    hold_ticks_q;
  logic [BANDS-1:0]               valid_q;
  logic                           rd_valid_q;
  phbm_pkg::band_rec_t            rd_data_q;
  phbm_pkg::band_rec_t            mem_q [BANDS];

  logic                           out_valid_q;
  logic [phbm_pkg::BAND_W-1:0]    out_band_q;
  logic [phbm_pkg::LEVEL_W-1:0]   out_bar_q;
  logic [phbm_pkg::LEVEL_W-1:0]   out_peak_q;
  logic                           out_last_q;

  logic                           in_acc;
  logic                           in_range;
  logic                           slot_free;
  logic                           tick_emits;
  logic                           advance;
  logic                           emit;
  logic                           emit_last;
  logic                           rd_en;
  logic [IW-1:0]                  rd_addr;
  logic                           wr_en;
  logic [phbm_pkg::SUM_W-1:0]     rounded;
  logic [phbm_pkg::SCALED_W-1:0]  scaled;
  logic [phbm_pkg::LEVEL_W-1:0]   load_value;
  phbm_pkg::band_rec_t            cur_rec;
  phbm_pkg::band_rec_t            nxt_rec;
  phbm_pkg::upd_ctrl_t            upd_ctrl;

  // Input handshake: one item at a time.
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_range   = (32'(in_band_i) < BANDS);

  // The output register can take a new result when empty or being drained.
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign tick_emits = (32'(band_q) < NOUT);
  assign advance    = (state_q == ST_TICK) && (!tick_emits || slot_free);

  assign emit = ((state_q == ST_LD_UPD) && slot_free) ||
                ((state_q == ST_TICK) && advance && tick_emits);
  assign emit_last = (state_q == ST_LD_UPD) || (band_q == LAST_OUT);

  // Memory read requests: first band on a transfer, next band while walking.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = band_q + IW'(1);
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (in_command_i == phbm_pkg::CMD_TICK)) begin
          rd_en   = 1'b1;
          rd_addr = '0;
        end else if (in_acc && in_range) begin
          rd_en   = 1'b1;
          rd_addr = IW'(in_band_i);
        end
      end
      ST_TICK: begin
        rd_en = advance && (band_q != LAST_BAND);
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  assign wr_en = ((state_q == ST_LD_UPD) && slot_free) || advance;

  // Scale the registered product to pixels, rounding up and saturating.
  assign rounded    = phbm_pkg::SUM_W'(product_q) + phbm_pkg::ROUND_UP;
  assign scaled     = rounded[phbm_pkg::SUM_W-1:phbm_pkg::FRAC_W];
  assign load_value = (scaled > phbm_pkg::SCALED_W'(phbm_pkg::LEVEL_MAX)) ?
                      phbm_pkg::LEVEL_MAX : scaled[phbm_pkg::LEVEL_W-1:0];

  // Bands never written read as their reset state.
  assign cur_rec = rd_valid_q ? rd_data_q : phbm_pkg::RESET_REC;

  assign upd_ctrl.is_tick    = (state_q == ST_TICK);
  assign upd_ctrl.value      = load_value;
  assign upd_ctrl.hold_ticks = hold_ticks_q;

  phbm_band_update u_update (
    .ctrl_i (upd_ctrl),
    .cur_i  (cur_rec),
    .nxt_o  (nxt_rec)
  );

  // Band state memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[band_q] <= nxt_rec;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // Sequencer, configuration, valid bits and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      band_q       <= '0;
      sample_q     <= '0;
      product_q    <= '0;
      height_q     <= phbm_pkg::HEIGHT_RESET;
      hold_ticks_q <= phbm_pkg::HOLD_RESET;
      valid_q      <= '0;
      rd_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      out_band_q   <= '0;
      out_bar_q    <= '0;
      out_peak_q   <= '0;
      out_last_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          phbm_pkg::REG_DISPLAY_HEIGHT: height_q     <= cfg_wdata_i;
          phbm_pkg::REG_HOLD_TICKS:     hold_ticks_q <= cfg_wdata_i[phbm_pkg::HOLD_W-1:0];
          default: begin
          end
        endcase
      end

      if (rd_en) begin
        rd_valid_q <= valid_q[rd_addr];
      end
      if (wr_en) begin
        valid_q[band_q] <= 1'b1;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_acc && (in_command_i == phbm_pkg::CMD_TICK)) begin
            band_q  <= '0;
            state_q <= ST_TICK;
          end else if (in_acc && in_range) begin
            band_q   <= IW'(in_band_i);
            sample_q <= in_sample_value_i;
            state_q  <= ST_LD_MUL;
          end
        end
        ST_LD_MUL: begin
          product_q <= phbm_pkg::PROD_W'(sample_q) * phbm_pkg::PROD_W'(height_q);
          state_q   <= ST_LD_UPD;
        end
        ST_LD_UPD: begin
          if (slot_free) begin
            state_q <= ST_IDLE;
          end
        end
        ST_TICK: begin
          if (advance) begin
            if (band_q == LAST_BAND) begin
              state_q <= ST_IDLE;
            end else begin
              band_q <= band_q + IW'(1);
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase

      // Output register: load a new result or release the one taken.
      if (emit) begin
        out_valid_q <= 1'b1;
        out_band_q  <= phbm_pkg::BAND_W'(band_q);
        out_bar_q   <= nxt_rec.bar;
        out_peak_q  <= nxt_rec.peak;
        out_last_q  <= emit_last;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_band_index_o = out_band_q;
  assign out_bar_level_o  = out_bar_q;
  assign out_peak_level_o = out_peak_q;
  assign out_last_o       = out_last_q;

  // A new result never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> slot_free)
    else $error("result loaded over a pending result");

  // A read never targets the band being written in the same cycle.
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_en && wr_en) |-> (rd_addr != band_q))
    else $error("memory read and write hit the same band");

  // The walk ends right after the last band is written.
  a_walk_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (band_q == LAST_BAND)) |=> (state_q == ST_IDLE))
    else $error("tick walk did not end after the last band");

  // An accepted in-range load goes on to the multiply step.
  a_load_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_command_i == phbm_pkg::CMD_LOAD) && in_range) |=>
    (state_q == ST_LD_MUL))
    else $error("load transfer did not start the multiply step");

endmodule

[sim/tb_peak_hold_bar_meter_unit.sv]
// Self-checking testbench for peak_hold_bar_meter_unit: directed and random loads and ticks,
// checked result by result against an in-bench model of the bars, peaks and fall speeds.
// Depends on phbm_pkg and the peak_hold_bar_meter_unit RTL.
`timescale 1ns / 100ps

module tb_peak_hold_bar_meter_unit;

  localparam int unsigned METER_BANDS   = 32;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned IDLE_PCT      = 36;
  localparam int unsigned SETTLE_CYCLES = 40;

  // One band reading as the block reports it.
  typedef struct packed {
    logic [phbm_pkg::BAND_W-1:0]  band;
    logic [phbm_pkg::LEVEL_W-1:0] bar;
    logic [phbm_pkg::LEVEL_W-1:0] peak;
    logic                         last;
  } meter_reading_t;

  // Model of the meter state plus the queue of readings still to arrive.
  class meter_scoreboard;
    logic [phbm_pkg::LEVEL_W-1:0] height;
    logic [phbm_pkg::HOLD_W-1:0]  hold_limit;
    logic [phbm_pkg::LEVEL_W-1:0] bar [METER_BANDS];
    logic [phbm_pkg::LEVEL_W-1:0] peak [METER_BANDS];
    logic [phbm_pkg::SPEED_W-1:0] bar_speed [METER_BANDS];
    logic [phbm_pkg::SPEED_W-1:0] peak_speed [METER_BANDS];
    logic [phbm_pkg::HOLD_W-1:0]  held [METER_BANDS];
    meter_reading_t               readings_q[$];
    int unsigned                  errors;
    int unsigned                  loads;
    int unsigned                  ticks;
    int unsigned                  compared;

    function new();
      height     = phbm_pkg::HEIGHT_RESET;
      hold_limit = phbm_pkg::HOLD_RESET;
      for (int i = 0; i < METER_BANDS; i++) begin
        bar[i]        = 11'd1;
        peak[i]       = 11'd0;
        bar_speed[i]  = 8'd1;
        peak_speed[i] = 8'd1;
        held[i]       = 6'd0;
      end
    endfunction

    function void set_register(logic idx, logic [phbm_pkg::LEVEL_W-1:0] data);
      if (idx == phbm_pkg::REG_DISPLAY_HEIGHT) begin
        height = data;
      end else begin
        hold_limit = data[phbm_pkg::HOLD_W-1:0];
      end
    endfunction

    // Ceiling of sample * height / 32768, saturated at full level.
    function logic [phbm_pkg::LEVEL_W-1:0] pixel_level(logic [phbm_pkg::SAMPLE_W-1:0] sample);
      logic [31:0] scaled;
      scaled = (32'(sample) * 32'(height) + 32'd32767) >> 15;
      return (scaled > 32'(phbm_pkg::LEVEL_MAX)) ? phbm_pkg::LEVEL_MAX
                                                 : scaled[phbm_pkg::LEVEL_W-1:0];
    endfunction

    function logic [phbm_pkg::LEVEL_W-1:0] fallen(logic [phbm_pkg::LEVEL_W-1:0] level,
                                                  logic [phbm_pkg::SPEED_W-1:0] speed);
      return (level > 11'(speed)) ? level - 11'(speed) : 11'd0;
    endfunction

    function logic [phbm_pkg::SPEED_W-1:0] faster(logic [phbm_pkg::SPEED_W-1:0] speed);
      return (speed == phbm_pkg::SPEED_MAX) ? speed : speed + 8'd1;
    endfunction

    // Updates the model for one accepted transfer and queues the readings it causes.
    function void note_item(logic cmd, logic [phbm_pkg::BAND_W-1:0] band,
                            logic [phbm_pkg::SAMPLE_W-1:0] sample);
      logic [phbm_pkg::LEVEL_W-1:0] level;
      if (cmd == phbm_pkg::CMD_LOAD) begin
        loads++;
        level = pixel_level(sample);
        if (level > bar[band]) begin
          bar[band]        = level;
          bar_speed[band]  = 8'd0;
          peak_speed[band] = 8'd0;
        end
        if (level > peak[band]) begin
          peak[band]       = level;
          peak_speed[band] = 8'd0;
          held[band]       = 6'd0;
        end
        readings_q.push_back('{band, bar[band], peak[band], 1'b1});
      end else begin
        ticks++;
        for (int i = 0; i < METER_BANDS; i++) begin
          bar[i] = fallen(bar[i], bar_speed[i]);
          if (held[i] >= hold_limit) begin
            peak[i]       = fallen(peak[i], peak_speed[i]);
            peak_speed[i] = faster(peak_speed[i]);
          end
          bar_speed[i] = faster(bar_speed[i]);
          held[i]      = (held[i] == phbm_pkg::HOLD_MAX) ? held[i] : held[i] + 6'd1;
          readings_q.push_back('{phbm_pkg::BAND_W'(i), bar[i], peak[i],
                                 1'(i == METER_BANDS - 1)});
        end
      end
    endfunction

    function void check_reading(meter_reading_t got);
      meter_reading_t want;
      compared++;
      if (readings_q.size() == 0) begin
        $error("unexpected result: band_index %0d with nothing outstanding", got.band);
        errors++;
        return;
      end
      want = readings_q.pop_front();
      if (got.band != want.band) begin
        $error("band_index: expected %0d, actual %0d", want.band, got.band);
        errors++;
      end
      if (got.bar != want.bar) begin
        $error("bar_level: expected %0d, actual %0d", want.bar, got.bar);
        errors++;
      end
      if (got.peak != want.peak) begin
        $error("peak_level: expected %0d, actual %0d", want.peak, got.peak);
        errors++;
      end
      if (got.last != want.last) begin
        $error("last: expected %0d, actual %0d", want.last, got.last);
        errors++;
      end
    endfunction

    function int unsigned outstanding();
      return readings_q.size();
    endfunction

    function void flag_leftover();
      if (readings_q.size() != 0) begin
        $error("%0d expected results never arrived", readings_q.size());
        errors += readings_q.size();
      end
    endfunction
  endclass

  logic                          clk_i             = 1'b0;
  logic                          rst_ni            = 1'b0;
  logic                          in_valid_i        = 1'b0;
  logic                          in_stall_o;
  logic                          in_command_i      = phbm_pkg::CMD_LOAD;
  logic [phbm_pkg::BAND_W-1:0]   in_band_i         = '0;
  logic [phbm_pkg::SAMPLE_W-1:0] in_sample_value_i = '0;
  logic                          out_valid_o;
  logic                          out_stall_i       = 1'b0;
  logic [phbm_pkg::BAND_W-1:0]   out_band_index_o;
  logic [phbm_pkg::LEVEL_W-1:0]  out_bar_level_o;
  logic [phbm_pkg::LEVEL_W-1:0]  out_peak_level_o;
  logic                          out_last_o;
  logic                          cfg_we_i          = 1'b0;
  logic                          cfg_idx_i         = phbm_pkg::REG_DISPLAY_HEIGHT;
  logic [phbm_pkg::LEVEL_W-1:0]  cfg_wdata_i       = '0;

  logic                          calm              = 1'b0;
  int unsigned                   cycle_count       = 0;
  int unsigned                   settings          = 1;
  meter_scoreboard               sb;

  peak_hold_bar_meter_unit #(
    .BANDS(METER_BANDS)
  ) uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .in_command_i     (in_command_i),
    .in_band_i        (in_band_i),
    .in_sample_value_i(in_sample_value_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_band_index_o (out_band_index_o),
    .out_bar_level_o  (out_bar_level_o),
    .out_peak_level_o (out_peak_level_o),
    .out_last_o       (out_last_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i)
  );

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Random back-pressure on the result side, switched off during the calm stretch.
  always @(posedge clk_i) begin
    out_stall_i <= calm ? 1'b0 : 1'($urandom_range(99) < IDLE_PCT);
  end

  // Every result transfer is checked against the oldest expected reading.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_reading('{out_band_index_o, out_bar_level_o, out_peak_level_o, out_last_o});
    end
  end

  // Offers one item, with random idle cycles first, and waits for its transfer.
  task automatic send_item(logic cmd, logic [phbm_pkg::BAND_W-1:0] band,
                           logic [phbm_pkg::SAMPLE_W-1:0] sample);
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while (!calm && $urandom_range(99) < IDLE_PCT);
    end
    in_valid_i        <= 1'b1;
    in_command_i      <= cmd;
    in_band_i         <= band;
    in_sample_value_i <= sample;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_item(cmd, band, sample);
  endtask

  // Random item; samples lean towards zero, full scale, half scale, small values and values around half scale.
  task automatic random_item(int unsigned tick_pct);
    logic                          cmd;
    logic [phbm_pkg::BAND_W-1:0]   band;
    logic [phbm_pkg::SAMPLE_W-1:0] sample;
    cmd  = ($urandom_range(99) < tick_pct) ? phbm_pkg::CMD_TICK : phbm_pkg::CMD_LOAD;
    band = phbm_pkg::BAND_W'($urandom_range(METER_BANDS - 1));
    case ($urandom_range(7))
      0: sample = 16'h0000;
      1: sample = 16'hFFFF;
      2: sample = 16'h8000;
      3: sample = 16'($urandom_range(255));
      4: sample = 16'($urandom_range(16'h8000, 16'h7F00));
      default: sample = 16'($urandom_range(16'hFFFF));
    endcase
    send_item(cmd, band, sample);
  endtask

  // Waits until every expected reading has arrived and the block has gone quiet.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes both registers on consecutive edges; junk goes into the unused hold bits.
  task automatic configure(logic [phbm_pkg::LEVEL_W-1:0] height,
                           logic [phbm_pkg::HOLD_W-1:0] hold);
    logic [phbm_pkg::LEVEL_W-1:0] hold_word;
    hold_word   = {5'($urandom_range(31)), hold};
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= phbm_pkg::REG_DISPLAY_HEIGHT;
    cfg_wdata_i <= height;
    @(posedge clk_i);
    sb.set_register(phbm_pkg::REG_DISPLAY_HEIGHT, height);
    cfg_idx_i   <= phbm_pkg::REG_HOLD_TICKS;
    cfg_wdata_i <= hold_word;
    @(posedge clk_i);
    sb.set_register(phbm_pkg::REG_HOLD_TICKS, hold_word);
    cfg_we_i    <= 1'b0;
    settings++;
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at reset settings: a tick from the reset state, full scale,
    // half scale, a load equal to the bar, a smaller load, a zero load, then
    // enough ticks for a peak to outlast its hold and start falling.
    send_item(phbm_pkg::CMD_TICK, 5'd0, 16'h0000);
    send_item(phbm_pkg::CMD_LOAD, 5'd0, 16'hFFFF);
    send_item(phbm_pkg::CMD_LOAD, 5'd31, 16'h8000);
    send_item(phbm_pkg::CMD_LOAD, 5'd31, 16'h8000);
    send_item(phbm_pkg::CMD_LOAD, 5'd0, 16'h0001);
    send_item(phbm_pkg::CMD_LOAD, 5'd5, 16'h0000);
    send_item(phbm_pkg::CMD_LOAD, 5'd17, 16'h7FFF);
    repeat (14) send_item(phbm_pkg::CMD_TICK, 5'd31, 16'hFFFF);
    send_item(phbm_pkg::CMD_LOAD, 5'd0, 16'hFFFF);

    // Tallest display, peaks fall from the first tick.
    drain();
    configure(11'd2047, 6'd0);
    repeat (70) random_item(40);

    // One-pixel display, longest hold.
    drain();
    configure(11'd1, 6'd63);
    repeat (50) random_item(40);

    // Zero height: loads leave the state alone.
    drain();
    configure(11'd0, phbm_pkg::HOLD_RESET);
    repeat (15) random_item(40);

    // Random settings, starting with a stretch without idling on either side.
    drain();
    configure(11'($urandom_range(2047, 1)), 6'($urandom_range(63)));
    calm <= 1'b1;
    repeat (35) random_item(40);
    calm <= 1'b0;
    repeat (35) random_item(40);

    // Long run of ticks so that hold counts and fall speeds reach saturation;
    // the odd zero load must not restart anything.
    drain();
    configure(11'd2047, 6'd63);
    send_item(phbm_pkg::CMD_LOAD, 5'd0, 16'hFFFF);
    send_item(phbm_pkg::CMD_LOAD, 5'd9, 16'h8000);
    send_item(phbm_pkg::CMD_LOAD, 5'd20, 16'h0100);
    send_item(phbm_pkg::CMD_LOAD, 5'd31, 16'hFFFF);
    for (int k = 0; k < 270; k++) begin
      if (k % 45 == 44) begin
        send_item(phbm_pkg::CMD_LOAD, phbm_pkg::BAND_W'($urandom_range(METER_BANDS - 1)),
                  16'h0000);
      end else begin
        send_item(phbm_pkg::CMD_TICK, phbm_pkg::BAND_W'($urandom_range(METER_BANDS - 1)),
                  16'($urandom_range(16'hFFFF)));
      end
    end

    drain();
    sb.flag_leftover();
    $display("Covered %0d loads and %0d ticks across %0d register settings.",
             sb.loads, sb.ticks, settings);
    $display("Compared %0d band readings, %0d field mismatches.", sb.compared, sb.errors);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
